FILE: src/tmbd_pkg.sv
package tmbd_pkg;

    // Field widths
    localparam int POS_W      = 24;
    localparam int HALF_W     = 13;
    localparam int TILE_IDX_W = 8;
    localparam int CNT_W      = 5;
    localparam int CFG_W      = 9;
    localparam int CFG_IDX_W  = 1;

    // Tile arithmetic: box edge sums and signed tile indices
    localparam int NUM_W  = 26;
    localparam int Q_W    = 18;
    localparam int Q_BIAS = 65536;

    // Commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_BOX   = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAP_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_ROWS = 1'b1;

endpackage

FILE: src/tmbd_if.sv
interface tmbd_item_if;
    logic                                      valid;
    logic                                      ready;
    logic                                      command;
    logic        [tmbd_pkg::TILE_IDX_W-1:0]    tile_col;
    logic        [tmbd_pkg::TILE_IDX_W-1:0]    tile_row;
    logic                                      tile_is_wall;
    logic signed [tmbd_pkg::POS_W-1:0]         pos_x;
    logic signed [tmbd_pkg::POS_W-1:0]         pos_y;
    logic        [tmbd_pkg::HALF_W-1:0]        half_width;
    logic        [tmbd_pkg::HALF_W-1:0]        half_height;
    logic                                      box_solid;

    modport source (
        output valid, command, tile_col, tile_row, tile_is_wall,
               pos_x, pos_y, half_width, half_height, box_solid,
        input  ready
    );
    modport sink (
        input  valid, command, tile_col, tile_row, tile_is_wall,
               pos_x, pos_y, half_width, half_height, box_solid,
        output ready
    );
endinterface

interface tmbd_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [tmbd_pkg::POS_W-1:0]    new_x;
    logic signed [tmbd_pkg::POS_W-1:0]    new_y;
    logic        [tmbd_pkg::CNT_W-1:0]    push_count;
    logic                                 clamped;

    modport source (output valid, new_x, new_y, push_count, clamped, input ready);
    modport sink   (input  valid, new_x, new_y, push_count, clamped, output ready);
endinterface

interface tmbd_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [tmbd_pkg::CFG_IDX_W-1:0]       index;
    logic [tmbd_pkg::CFG_W-1:0]           data;

    modport source (output valid, index, data, input ready);
    modport sink   (input  valid, index, data, output ready);
endinterface

FILE: src/tmbd_floor_div.sv
module tmbd_floor_div #(
    parameter int TILE_SIZE_UNITS = 16
) (
    input  logic                               i_clk,
    input  logic signed [tmbd_pkg::NUM_W-1:0]  i_num,
    output logic signed [tmbd_pkg::Q_W-1:0]    o_quot
);
    localparam int LG    = $clog2(TILE_SIZE_UNITS);
    localparam int DIVN  = LG + 17;
    localparam int SH    = DIVN + LG;
    localparam int PW    = 2 * DIVN + 1;
    localparam int WHL_W = tmbd_pkg::NUM_W - 8;
    localparam logic [63:0] RECIP =
        ((64'd1 << SH) + 64'(TILE_SIZE_UNITS) - 64'd1) / 64'(TILE_SIZE_UNITS);
    localparam logic [63:0] BIAS = 64'(TILE_SIZE_UNITS) << 16;

    logic [WHL_W-1:0] w_whole;
    logic [DIVN-1:0]  w_biased;
    logic [PW-1:0]    r_prod;

    // Drop the fraction (floor), then bias by a whole multiple of the tile size
    assign w_whole  = i_num[tmbd_pkg::NUM_W-1:8];
    assign w_biased = {{(DIVN-WHL_W){w_whole[WHL_W-1]}}, w_whole} + BIAS[DIVN-1:0];

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(w_biased) * PW'(RECIP[DIVN:0]);
    end

    assign o_quot = tmbd_pkg::Q_W'(r_prod >> SH) - tmbd_pkg::Q_W'(tmbd_pkg::Q_BIAS);

endmodule

FILE: src/tile_map_box_depenetration_top.sv
// Tile-map box depenetration. A one-bit wall map of MAX_MAP_COLS x MAX_MAP_ROWS
// tiles sits in on-chip memory. After reset the block sweeps that memory clear,
// one tile per cycle; configuration writes are taken during the sweep, items
// are not. A command 0 item writes one tile and returns nothing. A command 1 item
// returns one result: for a solid box, the block finds the tile span under the
// box through a constant-reciprocal floor divider, sets up the walk, then visits
// each tile of the span in row-major order (first the memory read plus overlap,
// then the push through the one shared adder and saturator), and hands over the
// result. The per-tile overlap/push step sets the pace. Items are accepted only
// while the block is idle; a finished result waits in the output register and
// the next item is taken meanwhile. The configuration port is always ready.
module tile_map_box_depenetration_top #(
    parameter int TILE_SIZE_UNITS = 16,
    parameter int MAX_MAP_COLS    = 256,
    parameter int MAX_MAP_ROWS    = 256,
    parameter int MAX_SPAN_TILES  = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tmbd_cfg_if.sink      i_cfg,
    tmbd_item_if.sink     i_item,
    tmbd_result_if.source o_result
);
    localparam int DEPTH   = MAX_MAP_COLS * MAX_MAP_ROWS;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TILE_Q  = TILE_SIZE_UNITS * 256;
    localparam int TILE_H  = TILE_SIZE_UNITS * 128;
    localparam int POS_W   = tmbd_pkg::POS_W;
    localparam int Q_W     = tmbd_pkg::Q_W;
    localparam int CEN_W   = 28;
    localparam int OV_W    = 29;
    localparam int SUM_W   = 26;
    localparam int IDX13_W = 13;

    localparam logic signed [CEN_W-1:0] TQ_C = CEN_W'(TILE_Q);
    localparam logic signed [CEN_W-1:0] TH_C = CEN_W'(TILE_H);
    localparam logic signed [OV_W-1:0]  TH_O = OV_W'(TILE_H);
    localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'(8388607);
    localparam logic signed [SUM_W-1:0] POS_MIN = -SUM_W'(8388608);
    localparam logic [IDX13_W-1:0] MAX_COLS_13 = IDX13_W'(MAX_MAP_COLS);
    localparam logic [IDX13_W-1:0] MAX_ROWS_13 = IDX13_W'(MAX_MAP_ROWS);
    localparam logic [tmbd_pkg::CNT_W-1:0] CNT_MAX = '1;

    // Sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_SETUP = 3'd3;
    localparam logic [2:0] S_EVAL  = 3'd4;
    localparam logic [2:0] S_PUSH  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    function automatic logic [AW-1:0] f_addr(input logic [IDX13_W-1:0] row,
                                             input logic [IDX13_W-1:0] col);
        f_addr = AW'(32'(row) * 32'(MAX_MAP_COLS) + 32'(col));
    endfunction

    logic [2:0]                  r_state, n_state;
    logic [AW-1:0]               r_clr_addr;
    logic [2:0]                  r_k;
    logic [tmbd_pkg::CFG_W-1:0]  r_map_cols, r_map_rows;

    logic signed [POS_W-1:0]     r_x, r_y;
    logic [tmbd_pkg::HALF_W-1:0] r_hw, r_hh;
    logic signed [Q_W-1:0]       r_c0, r_c1, r_r0, r_r1, r_c, r_r;
    logic signed [CEN_W-1:0]     r_cen_x0, r_cen_x, r_cen_y;
    logic signed [OV_W-1:0]      r_ox, r_oy;
    logic                        r_dx_neg, r_dy_neg, r_in_map, r_wall;
    logic [tmbd_pkg::CNT_W-1:0]  r_pushes;
    logic                        r_hit;

    logic                        r_out_valid;
    logic signed [POS_W-1:0]     r_out_x, r_out_y;
    logic [tmbd_pkg::CNT_W-1:0]  r_out_cnt;
    logic                        r_out_hit;

    logic                        mem [DEPTH];

    logic                        w_in_acc, w_cfg_acc, w_out_free;
    logic                        w_wr_ok, w_mem_we, w_mem_wd;
    logic [AW-1:0]               w_mem_waddr, w_rd_addr;
    logic signed [tmbd_pkg::NUM_W-1:0] w_div_num;
    logic signed [Q_W-1:0]       w_quot, w_c_lim, w_r_lim, w_cols_q, w_rows_q;
    logic [IDX13_W-1:0]          w_cols_eff, w_rows_eff;
    logic signed [CEN_W-1:0]     w_c0_ext, w_r0_ext, w_x_ext, w_y_ext;
    logic signed [CEN_W-1:0]     w_dx, w_dy, w_adx, w_ady;
    logic signed [OV_W-1:0]      w_ox, w_oy;
    logic                        w_push, w_use_x, w_neg;
    logic signed [SUM_W-1:0]     w_base, w_delta, w_sum, w_sat;
    logic                        w_sat_hit;
    logic                        w_row_end, w_walk_end;

    assign w_in_acc   = i_item.valid && i_item.ready;
    assign w_cfg_acc  = i_cfg.valid && i_cfg.ready;
    assign w_out_free = !r_out_valid || o_result.ready;

    assign i_cfg.ready  = 1'b1;
    assign i_item.ready = (r_state == S_IDLE);

    assign o_result.valid      = r_out_valid;
    assign o_result.new_x      = r_out_x;
    assign o_result.new_y      = r_out_y;
    assign o_result.push_count = r_out_cnt;
    assign o_result.clamped    = r_out_hit;

    // Map bounds, limited to the storage
    assign w_cols_eff = ({4'd0, r_map_cols} > MAX_COLS_13) ? MAX_COLS_13 : {4'd0, r_map_cols};
    assign w_rows_eff = ({4'd0, r_map_rows} > MAX_ROWS_13) ? MAX_ROWS_13 : {4'd0, r_map_rows};
    assign w_cols_q   = {{(Q_W-IDX13_W){1'b0}}, w_cols_eff};
    assign w_rows_q   = {{(Q_W-IDX13_W){1'b0}}, w_rows_eff};

    // Tile write: ignore tiles outside the storage
    assign w_wr_ok = ({5'd0, i_item.tile_col} < MAX_COLS_13)
                  && ({5'd0, i_item.tile_row} < MAX_ROWS_13);

    // Single write port: clearing sweep or tile write
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_wd    = 1'b0;
        w_mem_waddr = r_clr_addr;
        if (r_state == S_CLEAR) begin
            w_mem_we = 1'b1;
        end else if (w_in_acc && i_item.command == tmbd_pkg::CMD_WRITE && w_wr_ok) begin
            w_mem_we    = 1'b1;
            w_mem_wd    = i_item.tile_is_wall;
            w_mem_waddr = f_addr({5'd0, i_item.tile_row}, {5'd0, i_item.tile_col});
        end
    end

    // Read address is meaningful only for in-map tiles; the hit is gated later
    assign w_rd_addr = f_addr(r_r[IDX13_W-1:0], r_c[IDX13_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_mem_waddr] <= w_mem_wd;
        end
        r_wall <= mem[w_rd_addr];
    end

    // Box edges into the floor divider, one per cycle
    always_comb begin
        case (r_k)
            3'd0:    w_div_num = {{2{r_x[POS_W-1]}}, r_x} - {13'd0, r_hw};
            3'd1:    w_div_num = {{2{r_x[POS_W-1]}}, r_x} + {13'd0, r_hw};
            3'd2:    w_div_num = {{2{r_y[POS_W-1]}}, r_y} - {13'd0, r_hh};
            default: w_div_num = {{2{r_y[POS_W-1]}}, r_y} + {13'd0, r_hh};
        endcase
    end

    tmbd_floor_div #(
        .TILE_SIZE_UNITS(TILE_SIZE_UNITS)
    ) u_div (
        .i_clk  (i_clk),
        .i_num  (w_div_num),
        .o_quot (w_quot)
    );

    // Span limit and first tile centers
    assign w_c_lim  = r_c0 + Q_W'(MAX_SPAN_TILES - 1);
    assign w_r_lim  = r_r0 + Q_W'(MAX_SPAN_TILES - 1);
    assign w_c0_ext = {{(CEN_W-Q_W){r_c0[Q_W-1]}}, r_c0};
    assign w_r0_ext = {{(CEN_W-Q_W){r_r0[Q_W-1]}}, r_r0};

    // Overlap of the running box with the current tile
    assign w_x_ext = {{(CEN_W-POS_W){r_x[POS_W-1]}}, r_x};
    assign w_y_ext = {{(CEN_W-POS_W){r_y[POS_W-1]}}, r_y};
    assign w_dx    = w_x_ext - r_cen_x;
    assign w_dy    = w_y_ext - r_cen_y;
    assign w_adx   = w_dx[CEN_W-1] ? -w_dx : w_dx;
    assign w_ady   = w_dy[CEN_W-1] ? -w_dy : w_dy;
    assign w_ox    = {{(OV_W-tmbd_pkg::HALF_W){1'b0}}, r_hw} + TH_O - {w_adx[CEN_W-1], w_adx};
    assign w_oy    = {{(OV_W-tmbd_pkg::HALF_W){1'b0}}, r_hh} + TH_O - {w_ady[CEN_W-1], w_ady};

    // Shared push adder and saturator; a tie pushes on y
    assign w_push  = r_in_map && r_wall && (r_ox > 0) && (r_oy > 0);
    assign w_use_x = (r_ox < r_oy);
    assign w_neg   = w_use_x ? r_dx_neg : r_dy_neg;
    assign w_base  = w_use_x ? {{(SUM_W-POS_W){r_x[POS_W-1]}}, r_x}
                             : {{(SUM_W-POS_W){r_y[POS_W-1]}}, r_y};
    assign w_delta = w_use_x ? r_ox[SUM_W-1:0] : r_oy[SUM_W-1:0];
    assign w_sum   = w_neg ? (w_base - w_delta) : (w_base + w_delta);
    assign w_sat_hit = (w_sum > POS_MAX) || (w_sum < POS_MIN);
    assign w_sat   = (w_sum > POS_MAX) ? POS_MAX : ((w_sum < POS_MIN) ? POS_MIN : w_sum);

    assign w_row_end  = (r_c == r_c1);
    assign w_walk_end = w_row_end && (r_r == r_r1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == AW'(DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_in_acc && i_item.command == tmbd_pkg::CMD_BOX) begin
                    n_state = i_item.box_solid ? S_DIV : S_DONE;
                end
            end
            S_DIV: begin
                if (r_k == 3'd4) n_state = S_SETUP;
            end
            S_SETUP: n_state = S_EVAL;
            S_EVAL:  n_state = S_PUSH;
            S_PUSH: begin
                n_state = w_walk_end ? S_DONE : S_EVAL;
            end
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_map_cols  <= '0;
            r_map_rows  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (w_cfg_acc) begin
                case (i_cfg.index)
                    tmbd_pkg::REG_MAP_COLS: r_map_cols <= i_cfg.data;
                    tmbd_pkg::REG_MAP_ROWS: r_map_rows <= i_cfg.data;
                    default: ;
                endcase
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                // Latch the box; hold the count and flag at zero
                r_x      <= i_item.pos_x;
                r_y      <= i_item.pos_y;
                r_hw     <= i_item.half_width;
                r_hh     <= i_item.half_height;
                r_k      <= 3'd0;
                r_pushes <= '0;
                r_hit    <= 1'b0;
            end
            S_DIV: begin
                r_k <= r_k + 3'd1;
                case (r_k)
                    3'd1:    r_c0 <= w_quot;
                    3'd2:    r_c1 <= w_quot;
                    3'd3:    r_r0 <= w_quot;
                    3'd4:    r_r1 <= w_quot;
                    default: ;
                endcase
            end
            S_SETUP: begin
                if (r_c1 > w_c_lim) r_c1 <= w_c_lim;
                if (r_r1 > w_r_lim) r_r1 <= w_r_lim;
                r_c      <= r_c0;
                r_r      <= r_r0;
                r_cen_x0 <= w_c0_ext * TQ_C + TH_C;
                r_cen_x  <= w_c0_ext * TQ_C + TH_C;
                r_cen_y  <= w_r0_ext * TQ_C + TH_C;
            end
            S_EVAL: begin
                r_ox     <= w_ox;
                r_oy     <= w_oy;
                r_dx_neg <= w_dx[CEN_W-1];
                r_dy_neg <= w_dy[CEN_W-1];
                r_in_map <= (r_c >= 0) && (r_r >= 0) && (r_c < w_cols_q) && (r_r < w_rows_q);
            end
            S_PUSH: begin
                if (w_push) begin
                    if (w_use_x) begin
                        r_x <= w_sat[POS_W-1:0];
                    end else begin
                        r_y <= w_sat[POS_W-1:0];
                    end
                    if (w_sat_hit) r_hit <= 1'b1;
                    if (r_pushes != CNT_MAX) r_pushes <= r_pushes + 1'b1;
                end
                // Advance row-major over the span
                if (w_row_end) begin
                    r_c     <= r_c0;
                    r_r     <= r_r + Q_W'(1);
                    r_cen_x <= r_cen_x0;
                    r_cen_y <= r_cen_y + TQ_C;
                end else begin
                    r_c     <= r_c + Q_W'(1);
                    r_cen_x <= r_cen_x + TQ_C;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_out_x   <= r_x;
                    r_out_y   <= r_y;
                    r_out_cnt <= r_pushes;
                    r_out_hit <= r_hit;
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: bench/tb_tile_map_box_depenetration_top.sv
module tb_tile_map_box_depenetration_top;

    // Field widths, taken from the package
    localparam int TILE_IDX_W = tmbd_pkg::TILE_IDX_W;
    localparam int POS_W      = tmbd_pkg::POS_W;
    localparam int HALF_W     = tmbd_pkg::HALF_W;
    localparam int CNT_W      = tmbd_pkg::CNT_W;
    localparam int CFG_W      = tmbd_pkg::CFG_W;
    localparam int CFG_IDX_W  = tmbd_pkg::CFG_IDX_W;

    // Block geometry, matching the defaults of the top level
    localparam int     TILE_UNITS  = 16;
    localparam int     MAX_COLS    = 256;
    localparam int     MAX_ROWS    = 256;
    localparam int     SPAN_TILES  = 5;
    localparam longint TILE_Q      = TILE_UNITS * 256;
    localparam longint TILE_HALF_Q = TILE_UNITS * 128;
    localparam longint POS_MAX     = 64'sd8388607;
    localparam longint POS_MIN     = -64'sd8388608;
    localparam int     HALF_MAX    = 8191;

    // Quiet cycles after the last result before a register write (a tile
    // write gives no result, so let it land), and at the end of the run
    // (longest box walk plus handover).
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 64;
    // Long output back-pressure, long enough that the block fills up
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        logic                    command;
        logic [TILE_IDX_W-1:0]   tile_col;
        logic [TILE_IDX_W-1:0]   tile_row;
        logic                    tile_is_wall;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [HALF_W-1:0]       half_width;
        logic [HALF_W-1:0]       half_height;
        logic                    box_solid;
    } box_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] new_x;
        logic signed [POS_W-1:0] new_y;
        logic [CNT_W-1:0]        push_count;
        logic                    clamped;
    } box_result_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Everything the bench drives starts at a known value
    box_item_t              drv_item  = '0;
    logic                   drv_valid = 1'b0;
    logic                   rcv_ready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data  = '0;

    tmbd_item_if   item_bus ();
    tmbd_result_if result_bus ();
    tmbd_cfg_if    cfg_bus ();

    assign item_bus.valid        = drv_valid;
    assign item_bus.command      = drv_item.command;
    assign item_bus.tile_col     = drv_item.tile_col;
    assign item_bus.tile_row     = drv_item.tile_row;
    assign item_bus.tile_is_wall = drv_item.tile_is_wall;
    assign item_bus.pos_x        = drv_item.pos_x;
    assign item_bus.pos_y        = drv_item.pos_y;
    assign item_bus.half_width   = drv_item.half_width;
    assign item_bus.half_height  = drv_item.half_height;
    assign item_bus.box_solid    = drv_item.box_solid;
    assign result_bus.ready      = rcv_ready;
    assign cfg_bus.valid         = cfg_valid;
    assign cfg_bus.index         = cfg_index;
    assign cfg_bus.data          = cfg_data;

    tile_map_box_depenetration_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_bus),
        .i_item   (item_bus),
        .o_result (result_bus)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the block: wall map (clear after reset) and map bounds
    bit          wall_copy [0:MAX_COLS*MAX_ROWS-1];
    int unsigned cols_reg = 0;
    int unsigned rows_reg = 0;

    box_item_t   pending_items [$];
    box_result_t expected_boxes [$];
    int          items_queued   = 0;
    int          items_taken    = 0;
    int          mismatches     = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_requests  = 0;
    int          hold_seen      = 0;
    int          hold_left      = 0;

    // ------------------------------------------------------------------
    // Box depenetration predictor
    // ------------------------------------------------------------------

    // Tile index of a Q.8 coordinate, rounding toward minus infinity
    function automatic longint floor_tile(longint a);
        longint q;
        q = a / TILE_Q;
        if ((a % TILE_Q) != 0 && a < 0)
            q -= 1;
        return q;
    endfunction

    // Saturate a running coordinate to the 24-bit signed range
    function automatic longint clamp_pos(longint v, inout bit hit);
        if (v > POS_MAX) begin
            hit = 1'b1;
            return POS_MAX;
        end
        if (v < POS_MIN) begin
            hit = 1'b1;
            return POS_MIN;
        end
        return v;
    endfunction

    function automatic box_result_t depenetrate_box(box_item_t it);
        box_result_t res;
        longint x, y, hw, hh, map_w, map_h;
        longint c_lo, c_hi, r_lo, r_hi, r, c;
        longint dx, dy, ox, oy;
        bit     hit;
        int     pushes;
        x      = longint'(it.pos_x);
        y      = longint'(it.pos_y);
        hw     = longint'(it.half_width);
        hh     = longint'(it.half_height);
        hit    = 1'b0;
        pushes = 0;
        if (it.box_solid) begin
            // Bounds above the storage size act as the storage size
            map_w = (cols_reg < MAX_COLS) ? longint'(cols_reg) : longint'(MAX_COLS);
            map_h = (rows_reg < MAX_ROWS) ? longint'(rows_reg) : longint'(MAX_ROWS);
            // Span under the starting bounds, capped from the low side
            c_lo = floor_tile(x - hw);
            c_hi = floor_tile(x + hw);
            r_lo = floor_tile(y - hh);
            r_hi = floor_tile(y + hh);
            if (c_hi > c_lo + SPAN_TILES - 1)
                c_hi = c_lo + SPAN_TILES - 1;
            if (r_hi > r_lo + SPAN_TILES - 1)
                r_hi = r_lo + SPAN_TILES - 1;
            for (r = r_lo; r <= r_hi; r++) begin
                for (c = c_lo; c <= c_hi; c++) begin
                    if (c < 0 || r < 0 || c >= map_w || r >= map_h)
                        continue;
                    if (!wall_copy[r * MAX_COLS + c])
                        continue;
                    // Overlap against the running centre, not the start
                    dx = x - (c * TILE_Q + TILE_HALF_Q);
                    dy = y - (r * TILE_Q + TILE_HALF_Q);
                    ox = hw + TILE_HALF_Q - ((dx < 0) ? -dx : dx);
                    oy = hh + TILE_HALF_Q - ((dy < 0) ? -dy : dy);
                    // Touching edges do not push
                    if (ox <= 0 || oy <= 0)
                        continue;
                    // Smaller overlap wins; a tie goes to y
                    if (ox < oy)
                        x = clamp_pos(x + ((dx >= 0) ? ox : -ox), hit);
                    else
                        y = clamp_pos(y + ((dy >= 0) ? oy : -oy), hit);
                    if (pushes < 31)
                        pushes++;
                end
            end
        end
        res.new_x      = x[POS_W-1:0];
        res.new_y      = y[POS_W-1:0];
        res.push_count = pushes[CNT_W-1:0];
        res.clamped    = hit;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Item driver: pops pending items, idles at random, and updates the
    // shadow state at the edge where the block takes each item.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            if (drv_valid && item_bus.ready) begin
                if (drv_item.command == tmbd_pkg::CMD_WRITE) begin
                    // Writes ignore the map bounds, only storage limits them
                    if (drv_item.tile_col < MAX_COLS && drv_item.tile_row < MAX_ROWS)
                        wall_copy[drv_item.tile_row * MAX_COLS + drv_item.tile_col] =
                            drv_item.tile_is_wall;
                end else begin
                    expected_boxes.insert(expected_boxes.size(), depenetrate_box(drv_item));
                end
                items_taken++;
            end
            // Offer a new item once the current one is gone (or none is up)
            if (!drv_valid || item_bus.ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    drv_item  <= pending_items.pop_front();
                    drv_valid <= 1'b1;
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rcv_ready <= 1'b0;
            hold_left = 0;
        end else if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
            rcv_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            rcv_ready <= 1'b0;
        end else begin
            rcv_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each taken result with the oldest expected
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        box_result_t got, want;
        if (i_rst_n && result_bus.valid && rcv_ready) begin
            got = {result_bus.new_x, result_bus.new_y, result_bus.push_count,
                   result_bus.clamped};
            if (expected_boxes.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected box result: x=%0d y=%0d pushes=%0d clamped=%0b",
                             got.new_x, got.new_y, got.push_count, got.clamped);
                mismatches++;
            end else begin
                want = expected_boxes.pop_front();
                if (got.new_x !== want.new_x || got.new_y !== want.new_y ||
                    got.push_count !== want.push_count || got.clamped !== want.clamped) begin
                    if (mismatches < 10)
                        $display("box result wrong: expected x=%0d y=%0d pushes=%0d clamped=%0b",
                                 want.new_x, want.new_y, want.push_count, want.clamped,
                                 ", got x=%0d y=%0d pushes=%0d clamped=%0b",
                                 got.new_x, got.new_y, got.push_count, got.clamped);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic box_item_t random_item();
        box_item_t it;
        it.command      = 1'($urandom);
        it.tile_col     = TILE_IDX_W'($urandom);
        it.tile_row     = TILE_IDX_W'($urandom);
        it.tile_is_wall = 1'($urandom);
        it.pos_x        = POS_W'($urandom);
        it.pos_y        = POS_W'($urandom);
        it.half_width   = HALF_W'($urandom);
        it.half_height  = HALF_W'($urandom);
        it.box_solid    = 1'($urandom);
        return it;
    endfunction

    // Tile write; the unused box fields carry noise
    function automatic box_item_t tile_write(int col, int row, bit wall);
        box_item_t it;
        it              = random_item();
        it.command      = tmbd_pkg::CMD_WRITE;
        it.tile_col     = col[TILE_IDX_W-1:0];
        it.tile_row     = row[TILE_IDX_W-1:0];
        it.tile_is_wall = wall;
        return it;
    endfunction

    function automatic box_item_t box_item(longint x, longint y, int hw, int hh, bit solid);
        box_item_t it;
        it             = random_item();
        it.command     = tmbd_pkg::CMD_BOX;
        it.pos_x       = x[POS_W-1:0];
        it.pos_y       = y[POS_W-1:0];
        it.half_width  = hw[HALF_W-1:0];
        it.half_height = hh[HALF_W-1:0];
        it.box_solid   = solid;
        return it;
    endfunction

    task automatic offer(box_item_t it);
        pending_items.insert(pending_items.size(), it);
        items_queued++;
    endtask

    // Hold the sender until every item is taken and every result is back
    task automatic drain();
        while (items_taken != items_queued)
            @(posedge i_clk);
        while (expected_boxes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_bus.ready)
            @(posedge i_clk);
        if (idx == tmbd_pkg::REG_MAP_COLS)
            cols_reg = 32'(val);
        else
            rows_reg = 32'(val);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed traffic around one window of the map: walls written
    // there, boxes dropped over it, a little pure noise mixed in.
    task automatic random_chunk(int n_items);
        int     base_c, base_r, wall_pct, k, pick, hw, hh;
        longint x, y;
        base_c   = ($urandom_range(3) == 0) ? 244 : $urandom_range(4);
        base_r   = ($urandom_range(3) == 0) ? 244 : $urandom_range(4);
        wall_pct = $urandom_range(75, 25);
        for (k = 0; k < n_items; k++) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                offer(random_item());
            end else if (pick < 36) begin
                if ($urandom_range(9) == 0)
                    offer(tile_write($urandom_range(255), $urandom_range(255),
                                     $urandom_range(1) != 0));
                else
                    offer(tile_write(base_c + $urandom_range(11), base_r + $urandom_range(11),
                                     $urandom_range(99) < wall_pct));
            end else begin
                x  = base_c * TILE_Q - 6000 + $urandom_range(12 * TILE_Q + 12000);
                y  = base_r * TILE_Q - 6000 + $urandom_range(12 * TILE_Q + 12000);
                hw = ($urandom_range(9) < 7) ? $urandom_range(3000) : $urandom_range(HALF_MAX);
                hh = ($urandom_range(9) < 7) ? $urandom_range(3000) : $urandom_range(HALF_MAX);
                offer(box_item(x, y, hw, hh, $urandom_range(9) != 0));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : run_sequence
        int phase;
        int set_cols [8];
        int set_rows [8];
        set_cols = '{16, 256, 7, 511, 1, 300, 0, 12};
        set_rows = '{16, 256, 511, 9, 1, 20, 256, 12};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full map; the block is still sweeping its memory, which is fine
        // for register writes
        write_reg(tmbd_pkg::REG_MAP_COLS, 9'd256);
        write_reg(tmbd_pkg::REG_MAP_ROWS, 9'd256);

        // Directed: a few walls, then one box per corner of the behavior
        offer(tile_write(0, 0, 1'b1));
        offer(tile_write(1, 0, 1'b1));
        offer(tile_write(2, 2, 1'b1));
        offer(tile_write(255, 255, 1'b1));
        offer(tile_write(255, 0, 1'b1));
        offer(tile_write(1, 0, 1'b0));
        // x overlap smaller: push along x
        offer(box_item(TILE_HALF_Q + 1000, TILE_HALF_Q, 1000, 1000, 1'b1));
        // equal overlaps: push along y
        offer(box_item(TILE_HALF_Q + 500, TILE_HALF_Q + 500, 1000, 1000, 1'b1));
        // edge exactly on the wall: no push
        offer(box_item(TILE_Q + TILE_HALF_Q, TILE_HALF_Q, TILE_HALF_Q, TILE_HALF_Q, 1'b1));
        // non-solid box over a wall comes back unchanged
        offer(box_item(TILE_HALF_Q, TILE_HALF_Q, HALF_MAX, HALF_MAX, 1'b0));
        // negative tiles skipped
        offer(box_item(-100, -100, HALF_MAX, HALF_MAX, 1'b1));
        // coordinate extremes, far from the map
        offer(box_item(POS_MAX, POS_MAX, HALF_MAX, HALF_MAX, 1'b1));
        offer(box_item(POS_MIN, POS_MIN, 0, 0, 1'b1));
        offer(box_item(POS_MIN, POS_MAX, HALF_MAX, 0, 1'b1));
        // last tile of storage, zero-size box
        offer(box_item(255 * TILE_Q + TILE_HALF_Q, 255 * TILE_Q + TILE_HALF_Q, 0, 0, 1'b1));
        // widest box over the wall cluster
        offer(box_item(2 * TILE_Q, 2 * TILE_Q, HALF_MAX, HALF_MAX, 1'b1));
        offer(box_item(2 * TILE_Q + TILE_HALF_Q, 2 * TILE_Q + TILE_HALF_Q, 0, 0, 1'b1));
        drain();

        // Empty map bounds: walls exist but lie outside, and writes still land
        write_reg(tmbd_pkg::REG_MAP_COLS, 9'd0);
        write_reg(tmbd_pkg::REG_MAP_ROWS, 9'd0);
        offer(box_item(TILE_HALF_Q + 300, TILE_HALF_Q, 2000, 2000, 1'b1));
        offer(tile_write(0, 1, 1'b1));
        drain();

        // Bounds past storage act as full storage
        write_reg(tmbd_pkg::REG_MAP_COLS, 9'd511);
        write_reg(tmbd_pkg::REG_MAP_ROWS, 9'd511);
        offer(box_item(TILE_HALF_Q, TILE_Q + TILE_HALF_Q - 200, 1500, 900, 1'b1));
        offer(box_item(255 * TILE_Q + 100, 255 * TILE_Q + 3000, HALF_MAX, 4000, 1'b1));
        drain();

        // Random phases, cycling through idle modes and map bounds
        for (phase = 0; phase < 8; phase++) begin
            write_reg(tmbd_pkg::REG_MAP_COLS, CFG_W'(set_cols[phase]));
            write_reg(tmbd_pkg::REG_MAP_ROWS, CFG_W'(set_rows[phase]));
            case (phase % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 86;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 86;
                end
                default: begin
                    send_idle_pct  = 21;
                    recv_stall_pct = 21;
                end
            endcase
            random_chunk(110);
            // Back up the output while the sender keeps pushing
            if (phase == 4)
                hold_requests++;
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_boxes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: several times the slowest correct run, sweep included
    initial begin
        #12000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
